// ===== sv/mfqs_pkg.sv =====
`timescale 1ns / 1ps

package mfqs_pkg;

    // Event kinds carried by an input item.
    typedef enum logic [1:0] {
        OP_ADMIT  = 2'd0,
        OP_READY  = 2'd1,
        OP_DONE   = 2'd2,
        OP_EXPIRE = 2'd3
    } t_op;

    // Result kinds.
    typedef enum logic [1:0] {
        ACT_QUEUED   = 2'd0,
        ACT_DISPATCH = 2'd1,
        ACT_IDLE     = 2'd2,
        ACT_STALE    = 2'd3
    } t_action;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LEVEL_COUNT = 3'd0;
    localparam logic [2:0] CFG_SLICE0      = 3'd1;
    localparam logic [2:0] CFG_SLICE1      = 3'd2;
    localparam logic [2:0] CFG_SLICE2      = 3'd3;
    localparam logic [2:0] CFG_SLICE3      = 3'd4;

    localparam logic [2:0]  RST_LEVEL_COUNT = 3'd4;
    localparam logic [15:0] UNLIMITED_SLICE = 16'hFFFF;

    // One scheduling event as it waits between front and back.
    typedef struct packed {
        logic        arrival;
        t_op         op;
        logic [5:0]  task_id;
        logic [31:0] now;
        logic [1:0]  start_level;
        logic [15:0] burst_length;
    } t_event;

    // One result item.
    typedef struct packed {
        t_action     action;
        logic [5:0]  run_task;
        logic [1:0]  run_level;
        logic [31:0] deadline;
        logic        deadline_is_slice;
        logic        preempted;
        logic [5:0]  preempted_task;
    } t_result;

endpackage

// ===== sv/mfqs_evq.sv =====
`timescale 1ns / 1ps

// Front part: classifies incoming events and holds up to two of them.
module mfqs_evq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mfqs_pkg::t_op      i_op,
    input  logic [5:0]         i_task_id,
    input  logic [31:0]        i_now,
    input  logic [1:0]         i_start_level,
    input  logic [15:0]        i_burst_length,
    output logic               o_full,
    output logic               o_valid,
    output mfqs_pkg::t_event   o_event,
    input  logic               i_take
);

    mfqs_pkg::t_event r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_in;
    logic       w_out;
    mfqs_pkg::t_event w_ev;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_event = r_slot[r_rp];
    assign w_in    = i_push && !o_full;
    assign w_out   = i_take && o_valid;

    // Classification of the event kind.
    always_comb begin
        w_ev.arrival      = (i_op == mfqs_pkg::OP_ADMIT) || (i_op == mfqs_pkg::OP_READY);
        w_ev.op           = i_op;
        w_ev.task_id      = i_task_id;
        w_ev.now          = i_now;
        w_ev.start_level  = i_start_level;
        w_ev.burst_length = i_burst_length;
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in) r_wp <= !r_wp;
            if (w_out) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_in} - {1'b0, w_out};
        end
    end

    // Payload storage.
    always_ff @(posedge i_clk) begin
        if (w_in) r_slot[r_wp] <= w_ev;
    end

endmodule

// ===== sv/mfqs_core.sv =====
`timescale 1ns / 1ps

// Back part: sequencer over the task table and the per-level ready queues.
module mfqs_core #(
    parameter int LEVELS = 4,
    parameter int TASKS  = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ev_valid,
    input  mfqs_pkg::t_event  i_event,
    output logic              o_ev_take,
    input  logic [2:0]        i_level_count,
    input  logic [15:0]       i_slice [4],
    output logic              o_res_valid,
    output mfqs_pkg::t_result o_result,
    input  logic              i_res_take
);

    localparam int TW = $clog2(TASKS);
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW = $clog2(TASKS + 1);
    localparam int AW = $clog2(LEVELS * TASKS);
    localparam int EW = LW + 16;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_RUN  = 7'b0000010,
        ST_TSK  = 7'b0000100,
        ST_PRE  = 7'b0001000,
        ST_POP  = 7'b0010000,
        ST_PID  = 7'b0100000,
        ST_DSP  = 7'b1000000
    } t_state;

    t_state r_state;

    // Task table {level, remaining} and the ready queue store.
    logic [EW-1:0] r_tmem [TASKS];
    logic [TW-1:0] r_rq   [LEVELS * TASKS];
    logic [EW-1:0] r_tdata;
    logic [TW-1:0] r_qdata;

    logic [TW-1:0] r_head [LEVELS];
    logic [CW-1:0] r_cnt  [LEVELS];
    logic [TW-1:0] r_run;
    logic          r_busy;
    logic [31:0]   r_start;

    mfqs_pkg::t_event r_ev;
    logic [LW-1:0] r_rlvl;
    logic [15:0]   r_rrem;
    logic [LW-1:0] r_nlvl;
    logic [15:0]   r_nrem;

    mfqs_pkg::t_result r_out;
    logic              r_out_valid;
    mfqs_pkg::t_result w_pre;

    // Memory controls.
    logic          tm_we;
    logic [TW-1:0] tm_waddr;
    logic [EW-1:0] tm_wdata;
    logic          tm_re;
    logic [TW-1:0] tm_raddr;
    logic          rq_re;
    logic [AW-1:0] rq_raddr;

    logic          push_en;
    logic [LW-1:0] push_lvl;
    logic [TW-1:0] push_pid;
    logic [CW:0]   push_sum;
    logic [TW-1:0] push_pos;
    logic [AW-1:0] push_addr;
    logic          push_ok;

    logic          pk_found;
    logic [LW-1:0] pk_lvl;

    logic [TW-1:0] w_idx;
    logic [2:0]    w_eff;
    logic [LW-1:0] w_top;
    logic [LW-1:0] w_old_lvl;
    logic [LW-1:0] w_new_lvl;
    logic [LW-1:0] w_run_lvl;
    logic [31:0]   w_elapsed;
    logic [15:0]   w_charged;
    logic [LW-1:0] w_up_lvl;
    logic [LW-1:0] w_down_lvl;

    assign o_res_valid = r_out_valid;
    assign o_result    = r_out;
    assign o_ev_take   = (r_state == ST_IDLE) && i_ev_valid && !r_out_valid;

    // Decode of the current event against the stored state.
    always_comb begin
        // Task number folded onto the table size through a constant lookup.
        w_idx = '0;
        for (int v = 0; v < 64; v++) begin
            if (r_ev.task_id == 6'(v)) w_idx = TW'(v % TASKS);
        end
        if (i_level_count == 3'd0) w_eff = 3'd1;
        else if (32'(i_level_count) > LEVELS) w_eff = 3'(LEVELS);
        else w_eff = i_level_count;
        w_top = LW'(w_eff - 3'd1);
        w_old_lvl = r_tdata[EW-1:16];
        if (r_ev.op == mfqs_pkg::OP_ADMIT) begin
            w_new_lvl = (32'(r_ev.start_level) > 32'(w_top)) ? w_top : LW'(r_ev.start_level);
        end else begin
            w_new_lvl = w_old_lvl;
        end
        w_run_lvl  = (w_idx == r_run) ? w_new_lvl : r_rlvl;
        w_elapsed  = r_ev.now - r_start;
        w_charged  = (w_elapsed >= 32'(r_rrem)) ? 16'd0 : (r_rrem - w_elapsed[15:0]);
        w_up_lvl   = (r_rlvl != '0) ? (r_rlvl - LW'(1)) : r_rlvl;
        w_down_lvl = (32'(r_rlvl) < 32'(w_top)) ? (r_rlvl + LW'(1)) : r_rlvl;
    end

    // Highest-priority non-empty queue.
    always_comb begin
        pk_found = 1'b0;
        pk_lvl   = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_cnt[l] != '0) begin
                pk_found = 1'b1;
                pk_lvl   = LW'(l);
            end
        end
    end

    // Tail position of the queue being pushed.
    always_comb begin
        push_sum  = (CW + 1)'(r_head[push_lvl]) + (CW + 1)'(r_cnt[push_lvl]);
        push_pos  = (32'(push_sum) >= TASKS) ? TW'(32'(push_sum) - TASKS) : TW'(push_sum);
        push_addr = AW'(32'(push_lvl) * TASKS + 32'(push_pos));
        push_ok   = push_en && (32'(r_cnt[push_lvl]) < TASKS);
    end

    // Deadline of a dispatched task.
    function automatic mfqs_pkg::t_result dispatch_res(
        input logic [TW-1:0] pid,
        input logic [2:0]    lvl,
        input logic [15:0]   rem,
        input logic [31:0]   now,
        input logic [15:0]   s0,
        input logic [15:0]   s1,
        input logic [15:0]   s2,
        input logic [15:0]   s3
    );
        mfqs_pkg::t_result res;
        logic [15:0]       sl;
        logic              is_sl;
        unique case (lvl)
            3'd0:    sl = s0;
            3'd1:    sl = s1;
            3'd2:    sl = s2;
            3'd3:    sl = s3;
            default: sl = mfqs_pkg::UNLIMITED_SLICE;
        endcase
        is_sl                 = rem > sl;
        res                   = '0;
        res.action            = mfqs_pkg::ACT_DISPATCH;
        res.run_task          = 6'(pid);
        res.run_level         = lvl[1:0];
        res.deadline          = now + 32'(is_sl ? sl : rem);
        res.deadline_is_slice = is_sl;
        return res;
    endfunction

    // Result that carries only an action.
    function automatic mfqs_pkg::t_result status_res(input mfqs_pkg::t_action act);
        mfqs_pkg::t_result res;
        res        = '0;
        res.action = act;
        return res;
    endfunction

    // Result of a preemption: the new task runs and the old one is requeued.
    always_comb begin
        w_pre = dispatch_res(w_idx, 3'(r_nlvl), r_nrem, r_ev.now, i_slice[0], i_slice[1],
                             i_slice[2], i_slice[3]);
        w_pre.preempted      = 1'b1;
        w_pre.preempted_task = 6'(r_run);
    end

    // Memory accesses for each step.
    always_comb begin
        tm_we    = 1'b0;
        tm_waddr = w_idx;
        tm_wdata = {w_new_lvl, r_ev.burst_length};
        tm_re    = 1'b0;
        tm_raddr = r_run;
        rq_re    = 1'b0;
        rq_raddr = AW'(32'(pk_lvl) * TASKS + 32'(r_head[pk_lvl]));
        push_en  = 1'b0;
        push_lvl = w_new_lvl;
        push_pid = w_idx;
        unique case (r_state)
            ST_IDLE: tm_re = o_ev_take;
            ST_RUN: begin
                tm_re    = 1'b1;
                tm_raddr = w_idx;
            end
            ST_TSK: begin
                if (r_ev.arrival) begin
                    tm_we   = 1'b1;
                    push_en = r_busy && !(w_new_lvl < w_run_lvl);
                end else if (r_busy && (w_idx == r_run)) begin
                    tm_we = 1'b1;
                    if (r_ev.op == mfqs_pkg::OP_DONE) begin
                        tm_wdata = {w_up_lvl, r_rrem};
                    end else begin
                        tm_wdata = {w_down_lvl, w_charged};
                        push_en  = 1'b1;
                        push_lvl = w_down_lvl;
                    end
                end
            end
            ST_PRE: begin
                tm_we    = 1'b1;
                tm_waddr = r_run;
                tm_wdata = {r_rlvl, w_charged};
                push_en  = 1'b1;
                push_lvl = r_rlvl;
                push_pid = r_run;
            end
            ST_POP: rq_re = pk_found;
            ST_PID: begin
                tm_re    = 1'b1;
                tm_raddr = r_qdata;
            end
            ST_DSP: ;
            default: ;
        endcase
    end

    // Task table.
    always_ff @(posedge i_clk) begin
        if (tm_we) r_tmem[tm_waddr] <= tm_wdata;
        if (tm_re) r_tdata <= r_tmem[tm_raddr];
    end

    // Ready queue store.
    always_ff @(posedge i_clk) begin
        if (push_ok) r_rq[push_addr] <= push_pid;
        if (rq_re) r_qdata <= r_rq[rq_raddr];
    end

    // Queue heads and counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l] <= '0;
                r_cnt[l]  <= '0;
            end
        end else if (push_ok) begin
            r_cnt[push_lvl] <= r_cnt[push_lvl] + CW'(1);
        end else if (rq_re) begin
            r_cnt[pk_lvl]  <= r_cnt[pk_lvl] - CW'(1);
            r_head[pk_lvl] <= (32'(r_head[pk_lvl]) == TASKS - 1) ? '0
                                                                  : r_head[pk_lvl] + TW'(1);
        end
    end

    // Sequencer and running-task state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_run       <= '0;
            r_busy      <= 1'b0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_res_take && r_out_valid) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (o_ev_take) begin
                        r_ev    <= i_event;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_rlvl  <= r_tdata[EW-1:16];
                    r_rrem  <= r_tdata[15:0];
                    r_state <= ST_TSK;
                end
                ST_TSK: begin
                    r_state <= ST_IDLE;
                    if (r_ev.arrival) begin
                        if (!r_busy) begin
                            r_out <= dispatch_res(w_idx, 3'(w_new_lvl), r_ev.burst_length,
                                                  r_ev.now, i_slice[0], i_slice[1],
                                                  i_slice[2], i_slice[3]);
                            r_out_valid <= 1'b1;
                            r_busy      <= 1'b1;
                            r_run       <= w_idx;
                            r_start     <= r_ev.now;
                        end else if (w_new_lvl < w_run_lvl) begin
                            r_nlvl  <= w_new_lvl;
                            r_nrem  <= r_ev.burst_length;
                            r_state <= ST_PRE;
                        end else begin
                            r_out       <= status_res(mfqs_pkg::ACT_QUEUED);
                            r_out_valid <= 1'b1;
                        end
                    end else if (!r_busy || (w_idx != r_run)) begin
                        r_out       <= status_res(mfqs_pkg::ACT_STALE);
                        r_out_valid <= 1'b1;
                    end else begin
                        r_state <= ST_POP;
                    end
                end
                ST_PRE: begin
                    r_out       <= w_pre;
                    r_out_valid <= 1'b1;
                    r_run       <= w_idx;
                    r_start     <= r_ev.now;
                    r_state     <= ST_IDLE;
                end
                ST_POP: begin
                    if (pk_found) begin
                        r_state <= ST_PID;
                    end else begin
                        r_busy      <= 1'b0;
                        r_out       <= status_res(mfqs_pkg::ACT_IDLE);
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_PID: r_state <= ST_DSP;
                ST_DSP: begin
                    r_out <= dispatch_res(r_qdata, 3'(r_tdata[EW-1:16]), r_tdata[15:0],
                                          r_ev.now, i_slice[0], i_slice[1], i_slice[2],
                                          i_slice[3]);
                    r_out_valid <= 1'b1;
                    r_run       <= r_qdata;
                    r_start     <= r_ev.now;
                    r_state     <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/multilevel_feedback_queue_scheduler.sv =====
`timescale 1ns / 1ps

// Preemptive multilevel feedback queue scheduler. Events (admit, ready, burst
// done, slice expired) are pushed into a two-entry event queue and each yields
// one result in the result register. An event waits in the event queue until
// the back-end sequencer takes it. The sequencer reads the task table for the
// running task and then for the event's task. An event that queues, is stale
// or dispatches onto an idle CPU passes the run and task states to the result
// register; a preemption adds the requeue state, a burst done or slice expiry
// that leaves the CPU idle adds the queue pick, and a burst done or slice
// expiry that dispatches the next task adds queue pick, ready-store read and
// task table read. The sequencer waits for the previous result to be popped
// before it takes the next event.
// The task table and ready store need no clearing after reset.
module multilevel_feedback_queue_scheduler #(
    parameter int LEVELS = 4,
    parameter int TASKS  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_operation,
    input  logic [5:0]  i_task_id,
    input  logic [31:0] i_now,
    input  logic [1:0]  i_start_level,
    input  logic [15:0] i_burst_length,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [1:0]  o_action,
    output logic [5:0]  o_run_task,
    output logic [1:0]  o_run_level,
    output logic [31:0] o_deadline,
    output logic        o_deadline_is_slice,
    output logic        o_preempted,
    output logic [5:0]  o_preempted_task,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [2:0]  r_level_count;
    logic [15:0] r_slice [4];

    logic              w_ev_valid;
    logic              w_ev_take;
    mfqs_pkg::t_event  w_event;
    logic              w_res_valid;
    mfqs_pkg::t_result w_result;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_count <= mfqs_pkg::RST_LEVEL_COUNT;
            for (int i = 0; i < 4; i++) r_slice[i] <= mfqs_pkg::UNLIMITED_SLICE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mfqs_pkg::CFG_LEVEL_COUNT: r_level_count <= i_cfg_data[2:0];
                mfqs_pkg::CFG_SLICE0:      r_slice[0] <= i_cfg_data;
                mfqs_pkg::CFG_SLICE1:      r_slice[1] <= i_cfg_data;
                mfqs_pkg::CFG_SLICE2:      r_slice[2] <= i_cfg_data;
                mfqs_pkg::CFG_SLICE3:      r_slice[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: event queue.
    mfqs_evq u_evq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .i_op           (mfqs_pkg::t_op'(i_operation)),
        .i_task_id      (i_task_id),
        .i_now          (i_now),
        .i_start_level  (i_start_level),
        .i_burst_length (i_burst_length),
        .o_full         (o_full),
        .o_valid        (w_ev_valid),
        .o_event        (w_event),
        .i_take         (w_ev_take)
    );

    // Back: scheduling sequencer.
    mfqs_core #(
        .LEVELS (LEVELS),
        .TASKS  (TASKS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ev_valid    (w_ev_valid),
        .i_event       (w_event),
        .o_ev_take     (w_ev_take),
        .i_level_count (r_level_count),
        .i_slice       (r_slice),
        .o_res_valid   (w_res_valid),
        .o_result      (w_result),
        .i_res_take    (i_pop)
    );

    // Result ports.
    assign o_empty             = !w_res_valid;
    assign o_action            = w_result.action;
    assign o_run_task          = w_result.run_task;
    assign o_run_level         = w_result.run_level;
    assign o_deadline          = w_result.deadline;
    assign o_deadline_is_slice = w_result.deadline_is_slice;
    assign o_preempted         = w_result.preempted;
    assign o_preempted_task    = w_result.preempted_task;

endmodule
